// ----- src/dbse_pkg.sv -----
// dbse_pkg: shared types, codes, frame templates and crc helper of the door bus slave emulator
// no dependencies; imported by every file of the block but dbse_if and dbse_rx_mem
`timescale 1ns / 1ps
`default_nettype none
package dbse_pkg;

  localparam int RX_DEPTH_DEF = 255;

  // input command codes
  localparam logic [3:0] CMD_RX_BYTE   = 4'd0;
  localparam logic [3:0] CMD_FRAME_END = 4'd1;
  localparam logic [3:0] CMD_MS_TICK   = 4'd2;
  localparam logic [3:0] CMD_OPEN      = 4'd3;
  localparam logic [3:0] CMD_CLOSE     = 4'd4;
  localparam logic [3:0] CMD_STOP      = 4'd5;
  localparam logic [3:0] CMD_HALF      = 4'd6;
  localparam logic [3:0] CMD_VENT      = 4'd7;
  localparam logic [3:0] CMD_LAMP      = 4'd8;
  localparam logic [3:0] CMD_GOTO      = 4'd9;

  // configuration register indexes
  localparam logic [2:0] REG_DEV_ADDR    = 3'd0;
  localparam logic [2:0] REG_KEY_DELAY   = 3'd1;
  localparam logic [2:0] REG_ACT_TIMEOUT = 3'd2;
  localparam logic [2:0] REG_VENT_TARGET = 3'd3;
  localparam logic [2:0] REG_VENT_CODE   = 3'd4;

  // frame constants
  localparam logic [7:0]  FN_BCAST      = 8'h10;
  localparam logic [7:0]  FN_DEVICE     = 8'h17;
  localparam int          LEN_BCAST     = 27;
  localparam int          LEN_DEV_REQ   = 17;
  localparam int          LEN_SCAN_REQ  = 19;
  localparam int          LEN_MIN       = 5;
  localparam logic [7:0]  SUB_STATE     = 8'h08;
  localparam logic [7:0]  SUB_CMD02     = 8'h02;
  localparam logic [7:0]  LAMP_CODE_A   = 8'h10;
  localparam logic [7:0]  LAMP_CODE_B   = 8'h14;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;

  typedef enum logic [4:0] {
    KS_WAIT, KS_OPEN, KS_OPEN_R, KS_CLOSE, KS_CLOSE_R, KS_STOP, KS_STOP_R,
    KS_PO, KS_PO_R, KS_PO_P, KS_PC, KS_PC_R, KS_PC_P,
    KS_VENT, KS_VENT_R, KS_HALF, KS_HALF_R, KS_LAMP, KS_LAMP_R
  } key_t;

  typedef enum logic [2:0] {
    CS_IDLE, CS_READ, CS_DRAIN, CS_DECIDE, CS_EMIT
  } ctl_state_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_ACCEPT, OP_READ, OP_DECIDE, OP_EMIT
  } dp_op_t;

  typedef enum logic [2:0] {
    MODE_NONE, MODE_BCAST, MODE_STATE, MODE_CMD02, MODE_SCAN
  } mode_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic frame_go;
    logic rd_last;
    logic mode_none;
    logic emit_last;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic [7:0]  dev_addr;
    logic [15:0] key_delay;
    logic [15:0] act_timeout;
    logic [7:0]  vent_target;
    logic [7:0]  vent_code;
  } cfg_t;

  function automatic logic [15:0] crc_upd(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int j = 0; j < 8; j++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [4:0] tpl_len(input mode_t m);
    logic [4:0] l;
    unique case (m)
      MODE_STATE: l = 5'd21;
      MODE_CMD02: l = 5'd9;
      MODE_SCAN:  l = 5'd15;
      default:    l = 5'd1;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] tpl_byte(input mode_t m, input logic [4:0] i);
    logic [7:0] b;
    b = 8'h00;
    unique case (m)
      MODE_STATE: begin
        unique case (i)
          5'd0: b = 8'h02;
          5'd1: b = 8'h17;
          5'd2: b = 8'h10;
          5'd3: b = 8'h3E;
          5'd5: b = 8'h03;
          5'd6: b = 8'h01;
          default: b = 8'h00;
        endcase
      end
      MODE_CMD02: begin
        unique case (i)
          5'd0: b = 8'h02;
          5'd1: b = 8'h17;
          5'd2: b = 8'h04;
          5'd3: b = 8'h0F;
          5'd5: b = 8'h04;
          5'd6: b = 8'hFD;
          default: b = 8'h00;
        endcase
      end
      MODE_SCAN: begin
        unique case (i)
          5'd0:  b = 8'h02;
          5'd1:  b = 8'h17;
          5'd2:  b = 8'h0A;
          5'd5:  b = 8'h02;
          5'd6:  b = 8'h05;
          5'd7:  b = 8'h04;
          5'd8:  b = 8'h30;
          5'd9:  b = 8'h10;
          5'd10: b = 8'hFF;
          5'd11: b = 8'hA8;
          5'd12: b = 8'h45;
          default: b = 8'h00;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ----- src/dbse_if.sv -----
// dbse_in_if and dbse_out_if: valid/ready channels for input items and result items
// uses nothing but the fixed field widths of the block
`timescale 1ns / 1ps
`default_nettype none
interface dbse_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] command;
  logic [7:0] data_byte;
  logic [6:0] position;
  modport source (output valid, output command, output data_byte, output position, input ready);
  modport sink (input valid, input command, input data_byte, input position, output ready);
endinterface

interface dbse_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] tx_byte;
  logic       tx_last;
  logic       lamp_on;
  logic [7:0] door_position;
  logic [7:0] door_target;
  logic [7:0] door_state;
  logic [7:0] status_reserved;
  modport source (output valid, output result_kind, output tx_byte, output tx_last,
                  output lamp_on, output door_position, output door_target,
                  output door_state, output status_reserved, input ready);
  modport sink (input valid, input result_kind, input tx_byte, input tx_last,
                input lamp_on, input door_position, input door_target,
                input door_state, input status_reserved, output ready);
endinterface
`default_nettype wire

// ----- src/door_bus_slave_emulator.sv -----
// door_bus_slave_emulator: top level of the door bus slave emulator
// depends on dbse_pkg, dbse_if, dbse_cfg_regs, dbse_rx_mem, dbse_datapath, dbse_ctrl
`timescale 1ns / 1ps
`default_nettype none
//
// channel   direction  handshake          carries
// in_ch     in         valid/ready        command, data_byte, position
// out_ch    out        valid/ready        result_kind, tx_byte, tx_last, door status
// apb       in/out     psel/penable       five config registers at 4*i
//
// rx byte, tick and key request items are handled as they are taken, as is a frame end that is
// empty, shorter than five bytes or dropped after an overflow
// any other frame end of n stored bytes reads the n bytes through the crc unit, then passes
// the drain and decide states and emits its result items (up to 21) while out_ch takes them,
// or none when the frame causes no result
// the store has no reset: only bytes written since the last frame end are read
// a stalled out_ch holds the emission; the next item is taken once the frame is done
module door_bus_slave_emulator #(
  parameter int RX_DEPTH = dbse_pkg::RX_DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  dbse_in_if.sink     in_ch,
  dbse_out_if.source  out_ch,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dbse_pkg::*;

  localparam int AW = $clog2(RX_DEPTH);

  cfg_t          cfg;
  dp_cmd_t       cmd;
  dp_status_t    status;
  // receive store ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  // configuration registers
  dbse_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // received frame bytes
  dbse_rx_mem #(.DEPTH(RX_DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // sequencing
  dbse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // frame checks, key machine and result register
  dbse_datapath #(.RX_DEPTH(RX_DEPTH), .AW(AW)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .cmd                 (cmd),
    .status              (status),
    .in_command          (in_ch.command),
    .in_data_byte        (in_ch.data_byte),
    .in_position         (in_ch.position),
    .mem_we              (mem_we),
    .mem_waddr           (mem_waddr),
    .mem_wdata           (mem_wdata),
    .mem_raddr           (mem_raddr),
    .mem_rdata           (mem_rdata),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_result_kind     (out_ch.result_kind),
    .out_tx_byte         (out_ch.tx_byte),
    .out_tx_last         (out_ch.tx_last),
    .out_lamp_on         (out_ch.lamp_on),
    .out_door_position   (out_ch.door_position),
    .out_door_target     (out_ch.door_target),
    .out_door_state      (out_ch.door_state),
    .out_status_reserved (out_ch.status_reserved)
  );
endmodule
`default_nettype wire

// ----- src/dbse_cfg_regs.sv -----
// dbse_cfg_regs: apb-style configuration registers
// depends on dbse_pkg (cfg_t, register indexes)
`timescale 1ns / 1ps
`default_nettype none
module dbse_cfg_regs (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire  [4:0]        paddr,
  input  wire  [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output dbse_pkg::cfg_t    cfg
);
  import dbse_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dev_addr    <= 8'd2;
      cfg_r.key_delay   <= 16'd100;
      cfg_r.act_timeout <= 16'd2000;
      cfg_r.vent_target <= 8'd8;
      cfg_r.vent_code   <= 8'd10;
    end else if (wr_en) begin
      priority case (idx)
        REG_DEV_ADDR:    cfg_r.dev_addr    <= pwdata[7:0];
        REG_KEY_DELAY:   cfg_r.key_delay   <= pwdata[15:0];
        REG_ACT_TIMEOUT: cfg_r.act_timeout <= pwdata[15:0];
        REG_VENT_TARGET: cfg_r.vent_target <= pwdata[7:0];
        REG_VENT_CODE:   cfg_r.vent_code   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority case (idx)
      REG_DEV_ADDR:    prdata = {24'd0, cfg_r.dev_addr};
      REG_KEY_DELAY:   prdata = {16'd0, cfg_r.key_delay};
      REG_ACT_TIMEOUT: prdata = {16'd0, cfg_r.act_timeout};
      REG_VENT_TARGET: prdata = {24'd0, cfg_r.vent_target};
      REG_VENT_CODE:   prdata = {24'd0, cfg_r.vent_code};
      default:         prdata = 32'd0;
    endcase
  end
endmodule
`default_nettype wire

// ----- src/dbse_rx_mem.sv -----
// dbse_rx_mem: receive byte store, one write port and one registered read port
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none
module dbse_rx_mem #(
  parameter int DEPTH = 255,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire           clk,
  input  wire           we,
  input  wire  [AW-1:0] waddr,
  input  wire  [7:0]    wdata,
  input  wire  [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- src/dbse_datapath.sv -----
// dbse_datapath: frame bookkeeping, crc, door status, key state machine and result register
// depends on dbse_pkg; drives dbse_rx_mem ports, obeys commands from dbse_ctrl
`timescale 1ns / 1ps
`default_nettype none
module dbse_datapath #(
  parameter int RX_DEPTH = dbse_pkg::RX_DEPTH_DEF,
  parameter int AW       = $clog2(RX_DEPTH)
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  dbse_pkg::cfg_t        cfg,
  input  dbse_pkg::dp_cmd_t     cmd,
  output dbse_pkg::dp_status_t  status,
  input  wire  [3:0]            in_command,
  input  wire  [7:0]            in_data_byte,
  input  wire  [6:0]            in_position,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output logic [7:0]            mem_wdata,
  output logic [AW-1:0]         mem_raddr,
  input  wire  [7:0]            mem_rdata,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic                  out_result_kind,
  output logic [7:0]            out_tx_byte,
  output logic                  out_tx_last,
  output logic                  out_lamp_on,
  output logic [7:0]            out_door_position,
  output logic [7:0]            out_door_target,
  output logic [7:0]            out_door_state,
  output logic [7:0]            out_status_reserved
);
  import dbse_pkg::*;

  // receive side
  logic [AW-1:0] rx_count_r, rx_count_nxt;
  logic          skip_r, skip_nxt;
  logic [AW-1:0] n_r, n_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          pv_r;
  logic [AW-1:0] pidx_r;
  logic [7:0]    b0_r, b1_r, b5_r, b9_r, b10_r, b11_r, b12_r, b17_r, b20_r;
  logic [7:0]    crc_lo_r, crc_hi_r;
  logic [15:0]   rcrc_r, rcrc_nxt;
  logic [AW:0]   cnt_inc;

  // key machine and status
  key_t          ks_r, ks_nxt, pend_r, pend_nxt, ks0, pend0;
  logic [31:0]   ms_r, ms_nxt, stamp_r, stamp_nxt;
  logic [7:0]    goal_r, goal_nxt;
  logic          st_lamp_r, st_lamp_nxt, st_valid_r, st_valid_nxt;
  logic [7:0]    st_pos_r, st_pos_nxt, st_tgt_r, st_tgt_nxt;
  logic [7:0]    st_state_r, st_state_nxt, st_res_r, st_res_nxt;
  logic [7:0]    kb7_r, kb7_nxt, kb8_r, kb8_nxt, kb9_r, kb9_nxt;

  // emission
  mode_t         mode_r, mode_nxt;
  logic [4:0]    eidx_r, eidx_nxt, elen;
  logic [15:0]   tcrc_r, tcrc_nxt;
  logic [7:0]    ebyte;

  logic          load_out;
  logic          out_valid_r;
  logic          kind_r, last_r;
  logic [7:0]    txb_r;
  logic [7:0]    kind_byte;
  logic          kind_last;
  logic          o_lamp_r;
  logic [7:0]    o_pos_r, o_tgt_r, o_state_r, o_res_r;

  logic          el_delay, el_timeout, ks_free;
  logic          lamp_a, lamp_b, ch;
  logic [7:0]    ns;
  logic          addr_ok, crc_ok;

  assign el_delay   = (ms_r - stamp_r) > {16'd0, cfg.key_delay};
  assign el_timeout = (ms_r - stamp_r) > {16'd0, cfg.act_timeout};
  assign ks_free    = (ks_r == KS_WAIT) || (ks_r == KS_PO_P) || (ks_r == KS_PC_P);
  assign cnt_inc    = {1'b0, rx_count_r} + {{AW{1'b0}}, 1'b1};
  assign elen       = tpl_len(mode_r);
  assign addr_ok    = (b0_r == 8'h00) || (b0_r == cfg.dev_addr);
  assign crc_ok     = {crc_hi_r, crc_lo_r} == rcrc_r;

  // memory ports
  assign mem_we    = (cmd.op == OP_ACCEPT) && (in_command == CMD_RX_BYTE);
  assign mem_waddr = rx_count_r;
  assign mem_wdata = in_data_byte;
  assign mem_raddr = idx_r;

  // status to controller
  assign status.frame_go  = (in_command == CMD_FRAME_END) && (rx_count_r != '0) && !skip_r
                            && (rx_count_r >= AW'(LEN_MIN));
  assign status.rd_last   = idx_r == (n_r - {{(AW-1){1'b0}}, 1'b1});
  assign status.mode_none = mode_r == MODE_NONE;
  assign status.emit_last = (mode_r == MODE_BCAST) || (eidx_r == (elen - 5'd1));
  assign status.out_free  = !out_valid_r || out_ready;

  // capture of the received frame as it streams out of the store
  always_ff @(posedge clk) begin
    pidx_r <= idx_r;
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= cmd.op == OP_READ;
    end
    if (pv_r) begin
      if (pidx_r == AW'(0))  b0_r  <= mem_rdata;
      if (pidx_r == AW'(1))  b1_r  <= mem_rdata;
      if (pidx_r == AW'(5))  b5_r  <= mem_rdata;
      if (pidx_r == AW'(9))  b9_r  <= mem_rdata;
      if (pidx_r == AW'(10)) b10_r <= mem_rdata;
      if (pidx_r == AW'(11)) b11_r <= mem_rdata;
      if (pidx_r == AW'(12)) b12_r <= mem_rdata;
      if (pidx_r == AW'(17)) b17_r <= mem_rdata;
      if (pidx_r == AW'(20)) b20_r <= mem_rdata;
      if (pidx_r == (n_r - AW'(2))) crc_lo_r <= mem_rdata;
      if (pidx_r == (n_r - AW'(1))) crc_hi_r <= mem_rdata;
    end
  end

  // response byte with field overrides
  always_comb begin
    ebyte = tpl_byte(mode_r, eidx_r);
    priority case (eidx_r)
      5'd0: ebyte = b0_r;
      5'd3: ebyte = b11_r;
      5'd5: ebyte = b12_r;
      5'd7: if (mode_r == MODE_STATE) ebyte = kb7_r;
      5'd8: if (mode_r == MODE_STATE) ebyte = kb8_r;
      5'd9: if (mode_r == MODE_STATE) ebyte = kb9_r;
      default: ;
    endcase
  end

  always_comb begin
    rx_count_nxt = rx_count_r;
    skip_nxt     = skip_r;
    n_nxt        = n_r;
    idx_nxt      = idx_r;
    rcrc_nxt     = rcrc_r;
    ks_nxt       = ks_r;
    pend_nxt     = pend_r;
    ms_nxt       = ms_r;
    stamp_nxt    = stamp_r;
    goal_nxt     = goal_r;
    st_lamp_nxt  = st_lamp_r;
    st_pos_nxt   = st_pos_r;
    st_tgt_nxt   = st_tgt_r;
    st_state_nxt = st_state_r;
    st_res_nxt   = st_res_r;
    st_valid_nxt = st_valid_r;
    kb7_nxt      = kb7_r;
    kb8_nxt      = kb8_r;
    kb9_nxt      = kb9_r;
    mode_nxt     = mode_r;
    eidx_nxt     = eidx_r;
    tcrc_nxt     = tcrc_r;
    load_out     = 1'b0;
    kind_byte    = 8'h00;
    kind_last    = 1'b0;
    lamp_a       = b20_r == LAMP_CODE_A;
    lamp_b       = b20_r == LAMP_CODE_B;
    ns           = b11_r;
    ch           = 1'b0;
    ks0          = ks_r;
    pend0        = pend_r;

    unique case (cmd.op)
      OP_ACCEPT: begin
        priority case (in_command)
          CMD_RX_BYTE: begin
            if (cnt_inc >= (AW+1)'(RX_DEPTH)) begin
              rx_count_nxt = '0;
              skip_nxt     = 1'b1;
            end else begin
              rx_count_nxt = cnt_inc[AW-1:0];
            end
          end
          CMD_FRAME_END: begin
            if (rx_count_r != '0) begin
              if (!ks_free && el_timeout) ks_nxt = KS_WAIT;
              skip_nxt     = 1'b0;
              rx_count_nxt = '0;
              n_nxt        = rx_count_r;
              idx_nxt      = '0;
              rcrc_nxt     = CRC_INIT;
            end
          end
          CMD_MS_TICK: ms_nxt = ms_r + 32'd1;
          CMD_OPEN, CMD_CLOSE, CMD_HALF, CMD_VENT, CMD_LAMP: begin
            priority case (in_command)
              CMD_OPEN:  ks0 = KS_OPEN;
              CMD_CLOSE: ks0 = KS_CLOSE;
              CMD_HALF:  ks0 = KS_HALF;
              CMD_VENT:  ks0 = KS_VENT;
              default:   ks0 = KS_LAMP;
            endcase
            if (ks_r != KS_WAIT) begin
              pend_nxt = ks0;
            end else begin
              ks_nxt    = ks0;
              stamp_nxt = ms_r;
            end
          end
          CMD_STOP: begin
            if (ks_free) begin
              ks_nxt    = KS_STOP;
              stamp_nxt = ms_r;
            end else begin
              pend_nxt = KS_STOP;
            end
          end
          CMD_GOTO: begin
            if (ks_r == KS_WAIT) begin
              stamp_nxt = ms_r;
              if (in_position <= 7'd5) begin
                ks_nxt = KS_CLOSE;
              end else if (in_position >= 7'd95) begin
                ks_nxt = KS_OPEN;
              end else begin
                goal_nxt = {in_position, 1'b0};
                if ({in_position, 1'b0} > st_pos_r) ks_nxt = KS_PO;
                else if ({in_position, 1'b0} < st_pos_r) ks_nxt = KS_PC;
              end
            end
          end
          default: ;
        endcase
      end
      OP_READ: begin
        idx_nxt = idx_r + {{(AW-1){1'b0}}, 1'b1};
        if (pv_r && (pidx_r < (n_r - AW'(2)))) rcrc_nxt = crc_upd(rcrc_r, mem_rdata);
      end
      OP_DECIDE: begin
        mode_nxt = MODE_NONE;
        eidx_nxt = 5'd0;
        tcrc_nxt = CRC_INIT;
        kb7_nxt  = 8'h00;
        kb8_nxt  = 8'h00;
        kb9_nxt  = 8'h00;
        if (addr_ok && crc_ok) begin
          if (b1_r == FN_BCAST) begin
            if ((n_r == AW'(LEN_BCAST)) && (b0_r == 8'h00)) begin
              ch          = (st_lamp_r != lamp_a) || (!lamp_a && lamp_b);
              st_lamp_nxt = lamp_a || lamp_b;
              if (st_pos_r != b10_r) ch = 1'b1;
              if (st_tgt_r != b9_r)  ch = 1'b1;
              if ((b11_r == 8'h00) && (b9_r == cfg.vent_target) && (b9_r == b10_r))
                ns = cfg.vent_code;
              if (st_state_r != ns)  ch = 1'b1;
              if (st_res_r != b17_r) ch = 1'b1;
              if (!st_valid_r)       ch = 1'b1;
              st_pos_nxt   = b10_r;
              st_tgt_nxt   = b9_r;
              st_state_nxt = ns;
              st_res_nxt   = b17_r;
              st_valid_nxt = 1'b1;
              if (ch) mode_nxt = MODE_BCAST;
            end
          end else if ((b1_r == FN_DEVICE) && (b0_r == cfg.dev_addr)) begin
            if (n_r == AW'(LEN_DEV_REQ)) begin
              if (b5_r == SUB_STATE) begin
                mode_nxt = MODE_STATE;
                // backlog takeover then one key step
                if ((ks_r == KS_WAIT) && (pend_r != KS_WAIT)) begin
                  ks0   = pend_r;
                  pend0 = KS_WAIT;
                end
                pend_nxt = pend0;
                ks_nxt   = ks0;
                unique case (ks0)
                  KS_OPEN, KS_PO: begin
                    kb7_nxt = 8'h02; kb8_nxt = 8'h10; stamp_nxt = ms_r;
                    ks_nxt = (ks0 == KS_OPEN) ? KS_OPEN_R : KS_PO_R;
                  end
                  KS_CLOSE, KS_PC: begin
                    kb7_nxt = 8'h02; kb8_nxt = 8'h20; stamp_nxt = ms_r;
                    ks_nxt = (ks0 == KS_CLOSE) ? KS_CLOSE_R : KS_PC_R;
                  end
                  KS_STOP: begin
                    if ((st_pos_r == 8'd0) || (st_pos_r == 8'd100)) begin
                      ks_nxt = KS_WAIT;
                    end else begin
                      kb7_nxt = 8'h02; kb8_nxt = 8'h40; stamp_nxt = ms_r;
                      ks_nxt = KS_STOP_R;
                    end
                  end
                  KS_OPEN_R, KS_PO_R: begin
                    if (el_delay) begin
                      kb7_nxt = 8'h01; kb8_nxt = 8'h10;
                      ks_nxt = (ks0 == KS_OPEN_R) ? KS_WAIT : KS_PO_P;
                    end
                  end
                  KS_CLOSE_R, KS_PC_R: begin
                    if (el_delay) begin
                      kb7_nxt = 8'h01; kb8_nxt = 8'h20;
                      ks_nxt = (ks0 == KS_CLOSE_R) ? KS_WAIT : KS_PC_P;
                    end
                  end
                  KS_STOP_R: begin
                    if (el_delay) begin
                      kb7_nxt = 8'h01; kb8_nxt = 8'h40; ks_nxt = KS_WAIT;
                    end
                  end
                  KS_PO_P: begin
                    if (st_pos_r >= goal_r) begin
                      ks_nxt = KS_STOP; stamp_nxt = ms_r;
                    end
                  end
                  KS_PC_P: begin
                    if (st_pos_r <= goal_r) begin
                      ks_nxt = KS_STOP; stamp_nxt = ms_r;
                    end
                  end
                  KS_VENT: begin
                    kb7_nxt = 8'h02; kb9_nxt = 8'h40; stamp_nxt = ms_r; ks_nxt = KS_VENT_R;
                  end
                  KS_VENT_R: begin
                    if (el_delay) begin
                      kb7_nxt = 8'h01; kb9_nxt = 8'h40; ks_nxt = KS_WAIT;
                    end
                  end
                  KS_HALF: begin
                    kb7_nxt = 8'h02; kb9_nxt = 8'h04; stamp_nxt = ms_r; ks_nxt = KS_HALF_R;
                  end
                  KS_HALF_R: begin
                    if (el_delay) begin
                      kb7_nxt = 8'h01; kb9_nxt = 8'h04; ks_nxt = KS_WAIT;
                    end
                  end
                  KS_LAMP: begin
                    kb7_nxt = 8'h10; kb9_nxt = 8'h02; stamp_nxt = ms_r; ks_nxt = KS_LAMP_R;
                  end
                  KS_LAMP_R: begin
                    if (el_delay) begin
                      kb7_nxt = 8'h08; kb9_nxt = 8'h02; ks_nxt = KS_WAIT;
                    end
                  end
                  default: ;
                endcase
              end else if (b5_r == SUB_CMD02) begin
                mode_nxt = MODE_CMD02;
              end
            end else if (n_r == AW'(LEN_SCAN_REQ)) begin
              mode_nxt = MODE_SCAN;
            end
          end
        end
      end
      OP_EMIT: begin
        load_out = 1'b1;
        if (mode_r == MODE_BCAST) begin
          kind_last = 1'b1;
        end else begin
          eidx_nxt  = eidx_r + 5'd1;
          kind_last = eidx_r == (elen - 5'd1);
          if (eidx_r < (elen - 5'd2)) begin
            kind_byte = ebyte;
            tcrc_nxt  = crc_upd(tcrc_r, ebyte);
          end else if (eidx_r == (elen - 5'd2)) begin
            kind_byte = tcrc_r[7:0];
          end else begin
            kind_byte = tcrc_r[15:8];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_count_r  <= '0;
      skip_r      <= 1'b0;
      ks_r        <= KS_WAIT;
      pend_r      <= KS_WAIT;
      ms_r        <= 32'd0;
      stamp_r     <= 32'd0;
      goal_r      <= 8'd0;
      st_lamp_r   <= 1'b0;
      st_pos_r    <= 8'd0;
      st_tgt_r    <= 8'd0;
      st_state_r  <= 8'd0;
      st_res_r    <= 8'd0;
      st_valid_r  <= 1'b0;
      mode_r      <= MODE_NONE;
      out_valid_r <= 1'b0;
    end else begin
      rx_count_r  <= rx_count_nxt;
      skip_r      <= skip_nxt;
      ks_r        <= ks_nxt;
      pend_r      <= pend_nxt;
      ms_r        <= ms_nxt;
      stamp_r     <= stamp_nxt;
      goal_r      <= goal_nxt;
      st_lamp_r   <= st_lamp_nxt;
      st_pos_r    <= st_pos_nxt;
      st_tgt_r    <= st_tgt_nxt;
      st_state_r  <= st_state_nxt;
      st_res_r    <= st_res_nxt;
      st_valid_r  <= st_valid_nxt;
      mode_r      <= mode_nxt;
      if (load_out)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // status fields are copied into the result register so a later frame cannot alter a waiting item
  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    idx_r  <= idx_nxt;
    rcrc_r <= rcrc_nxt;
    kb7_r  <= kb7_nxt;
    kb8_r  <= kb8_nxt;
    kb9_r  <= kb9_nxt;
    eidx_r <= eidx_nxt;
    tcrc_r <= tcrc_nxt;
    if (load_out) begin
      kind_r    <= mode_r == MODE_BCAST;
      txb_r     <= kind_byte;
      last_r    <= kind_last;
      o_lamp_r  <= (mode_r == MODE_BCAST) ? st_lamp_r : 1'b0;
      o_pos_r   <= (mode_r == MODE_BCAST) ? st_pos_r : 8'd0;
      o_tgt_r   <= (mode_r == MODE_BCAST) ? st_tgt_r : 8'd0;
      o_state_r <= (mode_r == MODE_BCAST) ? st_state_r : 8'd0;
      o_res_r   <= (mode_r == MODE_BCAST) ? st_res_r : 8'd0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = kind_r;
  assign out_tx_byte         = txb_r;
  assign out_tx_last         = last_r;
  assign out_lamp_on         = o_lamp_r;
  assign out_door_position   = o_pos_r;
  assign out_door_target     = o_tgt_r;
  assign out_door_state      = o_state_r;
  assign out_status_reserved = o_res_r;
endmodule
`default_nettype wire

// ----- src/dbse_ctrl.sv -----
// dbse_ctrl: controller state machine sequencing frame read, decision and response
// depends on dbse_pkg (ctl_state_t, dp_cmd_t, dp_status_t)
`timescale 1ns / 1ps
`default_nettype none
module dbse_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  dbse_pkg::dp_status_t  status,
  output dbse_pkg::dp_cmd_t     cmd
);
  import dbse_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       acc;

  assign acc = in_valid && (state_r == CS_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE:   if (acc && status.frame_go) state_nxt = CS_READ;
      CS_READ:   if (status.rd_last) state_nxt = CS_DRAIN;
      CS_DRAIN:  state_nxt = CS_DECIDE;
      CS_DECIDE: state_nxt = CS_EMIT;
      CS_EMIT: begin
        if (status.mode_none) state_nxt = CS_IDLE;
        else if (status.out_free && status.emit_last) state_nxt = CS_IDLE;
      end
      default:   state_nxt = CS_IDLE;
    endcase
  end

  always_comb begin
    in_ready = state_r == CS_IDLE;
    cmd.op   = OP_NONE;
    unique case (state_r)
      CS_IDLE:   if (acc) cmd.op = OP_ACCEPT;
      CS_READ:   cmd.op = OP_READ;
      CS_DRAIN:  cmd.op = OP_NONE;
      CS_DECIDE: cmd.op = OP_DECIDE;
      CS_EMIT:   if (!status.mode_none && status.out_free) cmd.op = OP_EMIT;
      default:   cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// tb: self-checking testbench for door_bus_slave_emulator (modbus door-bus slave)
// depends on dbse_pkg, dbse_in_if / dbse_out_if and the rtl of the block
`timescale 1ns / 1ps
module tb;
  import dbse_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int SETTLE_CYCLES   = 320;   // longest frame end: 254 reads, drain and decide, 21 items
  localparam int RANDOM_ITEMS    = 330;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic       result_kind;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       lamp_on;
    logic [7:0] door_position;
    logic [7:0] door_target;
    logic [7:0] door_state;
    logic [7:0] status_reserved;
  } result_t;

  // answer templates of the device frames
  localparam logic [7:0] STATE_TPL[21] = '{8'h02, 8'h17, 8'h10, 8'h3E, 8'h00, 8'h03, 8'h01,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h74, 8'h1B};
  localparam logic [7:0] CMD02_TPL[9] = '{8'h02, 8'h17, 8'h04, 8'h0F, 8'h00, 8'h04, 8'hFD,
    8'h0A, 8'h72};
  localparam logic [7:0] SCAN_TPL[15] = '{8'h02, 8'h17, 8'h0A, 8'h00, 8'h00, 8'h02, 8'h05,
    8'h04, 8'h30, 8'h10, 8'hFF, 8'hA8, 8'h45, 8'h0E, 8'hDF};

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  dbse_in_if  in_ch ();
  dbse_out_if out_ch ();

  door_bus_slave_emulator dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------- predictor state: configuration ----------------
  logic [7:0]  m_dev_addr;
  logic [15:0] m_key_delay;
  logic [15:0] m_act_timeout;
  logic [7:0]  m_vent_target;
  logic [7:0]  m_vent_code;

  // ---------------- predictor state: block ----------------
  logic [7:0]  rx_bytes[256];
  logic [7:0]  rx_len;
  logic        drop_next;
  key_t        key_now;
  key_t        key_backlog;
  logic [31:0] ms_clock;
  logic [31:0] key_stamp;
  logic [7:0]  goal_pos;
  logic        s_lamp;
  logic [7:0]  s_pos, s_target, s_state, s_res;
  logic        s_valid;
  logic [7:0]  answer[32];

  result_t expected_results[$];

  int errors;
  int items_sent;
  int results_seen;
  int frames_answered;
  int status_reports;
  int sender_idle_pct;
  int recv_stall_pct;

  // ---------------- crc-16 over a byte queue ----------------
  function automatic logic [15:0] modbus_crc(input byte_q_t b, input int n);
    logic [15:0] c;
    c = 16'hFFFF;
    for (int i = 0; i < n; i++) begin
      c = c ^ {8'h00, b[i]};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic ms_passed(input logic [15:0] lim);
    logic [31:0] d;
    d = ms_clock - key_stamp;
    return d > {16'h0, lim};
  endfunction

  function automatic void key_press(input key_t nxt);
    key_now   = nxt;
    key_stamp = ms_clock;
  endfunction

  function automatic void key_request(input key_t s);
    if (key_now != KS_WAIT) key_backlog = s;
    else key_press(s);
  endfunction

  function automatic void key_release(input int idx, input logic [7:0] code, input key_t nxt);
    if (ms_passed(m_key_delay)) begin
      answer[7]   = 8'h01;
      answer[idx] = code;
      key_now     = nxt;
    end
  endfunction

  // one step of the key state machine, run when a state request is answered
  function automatic void key_advance();
    case (key_now)
      KS_OPEN:    begin answer[7] = 8'h02; answer[8] = 8'h10; key_press(KS_OPEN_R); end
      KS_OPEN_R:  key_release(8, 8'h10, KS_WAIT);
      KS_CLOSE:   begin answer[7] = 8'h02; answer[8] = 8'h20; key_press(KS_CLOSE_R); end
      KS_CLOSE_R: key_release(8, 8'h20, KS_WAIT);
      KS_STOP: begin
        if (s_pos == 8'd0 || s_pos == 8'd100) key_now = KS_WAIT;
        else begin answer[7] = 8'h02; answer[8] = 8'h40; key_press(KS_STOP_R); end
      end
      KS_STOP_R:  key_release(8, 8'h40, KS_WAIT);
      KS_PO:      begin answer[7] = 8'h02; answer[8] = 8'h10; key_press(KS_PO_R); end
      KS_PO_R:    key_release(8, 8'h10, KS_PO_P);
      KS_PO_P:    if (s_pos >= goal_pos) key_press(KS_STOP);
      KS_PC:      begin answer[7] = 8'h02; answer[8] = 8'h20; key_press(KS_PC_R); end
      KS_PC_R:    key_release(8, 8'h20, KS_PC_P);
      KS_PC_P:    if (s_pos <= goal_pos) key_press(KS_STOP);
      KS_VENT:    begin answer[7] = 8'h02; answer[9] = 8'h40; key_press(KS_VENT_R); end
      KS_VENT_R:  key_release(9, 8'h40, KS_WAIT);
      KS_HALF:    begin answer[7] = 8'h02; answer[9] = 8'h04; key_press(KS_HALF_R); end
      KS_HALF_R:  key_release(9, 8'h04, KS_WAIT);
      KS_LAMP:    begin answer[7] = 8'h10; answer[9] = 8'h02; key_press(KS_LAMP_R); end
      KS_LAMP_R: begin
        if (ms_passed(m_key_delay)) begin
          answer[7] = 8'h08; answer[9] = 8'h02; key_now = KS_WAIT;
        end
      end
      default: ;
    endcase
  endfunction

  // broadcast status frame: update door status, report only on a change
  function automatic void status_update();
    logic       changed;
    logic       v;
    logic [7:0] ns;
    result_t    r;
    changed = 1'b0;
    v = (rx_bytes[20] == 8'h10);
    if (s_lamp != v) begin s_lamp = v; changed = 1'b1; end
    if (!s_lamp) begin
      v = (rx_bytes[20] == 8'h14);
      if (s_lamp != v) begin s_lamp = v; changed = 1'b1; end
    end
    if (s_pos != rx_bytes[10]) begin s_pos = rx_bytes[10]; changed = 1'b1; end
    if (s_target != rx_bytes[9]) begin s_target = rx_bytes[9]; changed = 1'b1; end
    ns = rx_bytes[11];
    if (ns == 8'd0 && s_target == m_vent_target && s_target == s_pos) ns = m_vent_code;
    if (s_state != ns) begin s_state = ns; changed = 1'b1; end
    if (s_res != rx_bytes[17]) begin s_res = rx_bytes[17]; changed = 1'b1; end
    if (!s_valid) begin s_valid = 1'b1; changed = 1'b1; end
    if (changed) begin
      r = '{result_kind: 1'b1, tx_byte: 8'h00, tx_last: 1'b1, lamp_on: s_lamp,
            door_position: s_pos, door_target: s_target, door_state: s_state,
            status_reserved: s_res};
      expected_results.push_back(r);
      status_reports++;
    end
  endfunction

  function automatic int load_answer(input int which);
    int n;
    n = (which == 0) ? 21 : (which == 1) ? 9 : 15;
    for (int i = 0; i < n; i++)
      answer[i] = (which == 0) ? STATE_TPL[i] : (which == 1) ? CMD02_TPL[i] : SCAN_TPL[i];
    answer[0] = rx_bytes[0];
    answer[3] = rx_bytes[11];
    answer[5] = rx_bytes[12];
    return n;
  endfunction

  // decode a completed frame of n bytes
  function automatic void frame_decode(input int n);
    logic [7:0]  a;
    logic [15:0] c;
    byte_q_t     q;
    int          len;
    result_t     r;
    len = 0;
    if (n < 5) return;
    a = rx_bytes[0];
    if (a != 8'h00 && a != m_dev_addr) return;
    for (int i = 0; i < n - 2; i++) q.push_back(rx_bytes[i]);
    if ({rx_bytes[n-1], rx_bytes[n-2]} != modbus_crc(q, n - 2)) return;
    if (rx_bytes[1] == FN_BCAST) begin
      if (n == LEN_BCAST && a == 8'h00) status_update();
      return;
    end
    if (rx_bytes[1] != FN_DEVICE || a != m_dev_addr) return;
    if (n == LEN_DEV_REQ) begin
      if (rx_bytes[5] == SUB_STATE) begin
        len = load_answer(0);
        // backlog is taken over without a new time stamp
        if (key_now == KS_WAIT && key_backlog != KS_WAIT) begin
          key_now     = key_backlog;
          key_backlog = KS_WAIT;
        end
        key_advance();
      end else if (rx_bytes[5] == SUB_CMD02) begin
        len = load_answer(1);
      end
    end else if (n == LEN_SCAN_REQ) begin
      len = load_answer(2);
    end
    if (len == 0) return;
    q.delete();
    for (int i = 0; i < len - 2; i++) q.push_back(answer[i]);
    c = modbus_crc(q, len - 2);
    answer[len-2] = c[7:0];
    answer[len-1] = c[15:8];
    for (int i = 0; i < len; i++) begin
      r = '0;
      r.tx_byte = answer[i];
      r.tx_last = (i == len - 1);
      expected_results.push_back(r);
    end
    frames_answered++;
  endfunction

  function automatic void door_goto(input logic [6:0] p);
    if (key_now != KS_WAIT) return;
    if (p <= 7'd5) key_press(KS_CLOSE);
    else if (p >= 7'd95) key_press(KS_OPEN);
    else begin
      goal_pos  = {p, 1'b0};
      key_stamp = ms_clock;
      if (goal_pos > s_pos) key_now = KS_PO;
      else if (goal_pos < s_pos) key_now = KS_PC;
    end
  endfunction

  // expected results of one accepted input item
  function automatic void predict_item(input logic [3:0] cmd, input logic [7:0] d,
                                       input logic [6:0] p);
    case (cmd)
      CMD_RX_BYTE: begin
        rx_bytes[rx_len] = d;
        if (rx_len == 8'(RX_DEPTH_DEF - 1)) begin
          rx_len    = 8'd0;
          drop_next = 1'b1;
        end else rx_len = rx_len + 8'd1;
      end
      CMD_FRAME_END: begin
        if (rx_len != 8'd0) begin
          if (key_now != KS_WAIT && key_now != KS_PO_P && key_now != KS_PC_P
              && ms_passed(m_act_timeout))
            key_now = KS_WAIT;
          if (!drop_next) frame_decode(int'(rx_len));
          drop_next = 1'b0;
          rx_len    = 8'd0;
        end
      end
      CMD_MS_TICK: ms_clock = ms_clock + 32'd1;
      CMD_OPEN:    key_request(KS_OPEN);
      CMD_CLOSE:   key_request(KS_CLOSE);
      CMD_STOP: begin
        if (key_now == KS_WAIT || key_now == KS_PO_P || key_now == KS_PC_P) key_press(KS_STOP);
        else key_backlog = KS_STOP;
      end
      CMD_HALF:    key_request(KS_HALF);
      CMD_VENT:    key_request(KS_VENT);
      CMD_LAMP:    key_request(KS_LAMP);
      CMD_GOTO:    door_goto(p);
      default: ;
    endcase
  endfunction

  // ---------------- result checking ----------------
  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result item with nothing expected: kind %0d byte 0x%02h",
               out_ch.result_kind, out_ch.tx_byte);
        errors++;
      end else begin
        e = expected_results.pop_front();
        check_field("result_kind", 8'(e.result_kind), 8'(out_ch.result_kind));
        check_field("tx_byte", e.tx_byte, out_ch.tx_byte);
        check_field("tx_last", 8'(e.tx_last), 8'(out_ch.tx_last));
        check_field("lamp_on", 8'(e.lamp_on), 8'(out_ch.lamp_on));
        check_field("door_position", e.door_position, out_ch.door_position);
        check_field("door_target", e.door_target, out_ch.door_target);
        check_field("door_state", e.door_state, out_ch.door_state);
        check_field("status_reserved", e.status_reserved, out_ch.status_reserved);
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ch.ready <= (int'($urandom_range(99)) >= recv_stall_pct);
  end

  // watchdog: cycles in a row with no item accepted on either side
  int quiet_cycles;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog expired, %0d results still expected", expected_results.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  // ---------------- stimulus helpers ----------------
  // one input item; valid stays high after acceptance unless the next call idles
  task automatic send_item(input logic [3:0] cmd, input logic [7:0] d, input logic [6:0] p);
    while (int'($urandom_range(99)) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.data_byte <= d;
    in_ch.position  <= p;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(cmd, d, p);
    if (cmd <= CMD_GOTO) items_sent++;
  endtask

  // frame body, crc appended (optionally corrupted), then frame end
  task automatic send_frame(input byte_q_t body, input bit bad_crc);
    logic [15:0] c;
    c = modbus_crc(body, body.size());
    if (bad_crc) c = c ^ (16'h1 << $urandom_range(15));
    body.push_back(c[7:0]);
    body.push_back(c[15:8]);
    foreach (body[i]) send_item(CMD_RX_BYTE, body[i], 7'($urandom));
    send_item(CMD_FRAME_END, 8'($urandom), 7'($urandom));
  endtask

  function automatic byte_q_t random_body(input int n);
    byte_q_t q;
    for (int i = 0; i < n; i++) q.push_back(8'($urandom));
    return q;
  endfunction

  // device request: 0 state, 1 cmd02, 2 scan
  function automatic byte_q_t device_body(input int which);
    byte_q_t q;
    q = random_body(which == 2 ? LEN_SCAN_REQ - 2 : LEN_DEV_REQ - 2);
    q[0] = m_dev_addr;
    q[1] = FN_DEVICE;
    if (which == 0) q[5] = SUB_STATE;
    else if (which == 1) q[5] = SUB_CMD02;
    return q;
  endfunction

  function automatic byte_q_t status_body(input logic [7:0] pos, input logic [7:0] tgt,
                                          input logic [7:0] st, input logic [7:0] lamp);
    byte_q_t q;
    q = random_body(LEN_BCAST - 2);
    q[0]  = 8'h00;
    q[1]  = FN_BCAST;
    q[9]  = tgt;
    q[10] = pos;
    q[11] = st;
    q[20] = lamp;
    return q;
  endfunction

  task automatic ticks(input int n);
    repeat (n) send_item(CMD_MS_TICK, 8'($urandom), 7'($urandom));
  endtask

  // wait until every expected result arrived and the block has finished a silent frame
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_DEV_ADDR:    m_dev_addr    = value[7:0];
      REG_KEY_DELAY:   m_key_delay   = value[15:0];
      REG_ACT_TIMEOUT: m_act_timeout = value[15:0];
      REG_VENT_TARGET: m_vent_target = value[7:0];
      REG_VENT_CODE:   m_vent_code   = value[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] dev, input logic [15:0] dly,
                            input logic [15:0] tmo, input logic [7:0] vt, input logic [7:0] vc);
    drain();
    write_reg(REG_DEV_ADDR, 32'(dev));
    write_reg(REG_KEY_DELAY, 32'(dly));
    write_reg(REG_ACT_TIMEOUT, 32'(tmo));
    write_reg(REG_VENT_TARGET, 32'(vt));
    write_reg(REG_VENT_CODE, 32'(vc));
  endtask

  // ---------------- tests ----------------
  // status frames: first report, repeat without change, vent substitution, both lamp codes
  task automatic test_status_frames();
    send_frame(status_body(8'd0, 8'd0, 8'd3, 8'h00), 1'b0);
    send_frame(status_body(8'd0, 8'd0, 8'd3, 8'h00), 1'b0);
    send_frame(status_body(8'd0, 8'd0, 8'd3, 8'h00), 1'b0);
    send_frame(status_body(m_vent_target, m_vent_target, 8'd0, 8'h10), 1'b0);
    send_frame(status_body(8'd200, 8'd255, 8'hFF, 8'h14), 1'b0);
    send_frame(status_body(8'd100, 8'd100, 8'd0, 8'h14), 1'b0);
  endtask

  // device requests of every kind plus the frames that must be dropped and the unused command codes
  task automatic test_device_frames();
    byte_q_t q;
    send_frame(device_body(0), 1'b0);
    send_frame(device_body(1), 1'b0);
    send_frame(device_body(2), 1'b0);
    send_frame(device_body(0), 1'b1);                 // crc error
    q = device_body(0); q[0] = m_dev_addr + 8'd1;
    send_frame(q, 1'b0);                              // foreign address
    q = device_body(0); q[5] = 8'h55;
    send_frame(q, 1'b0);                              // unknown subcommand
    q = device_body(0); q[1] = 8'h03;
    send_frame(q, 1'b0);                              // unknown function
    q = device_body(0); q[0] = 8'h00;
    send_frame(q, 1'b0);                              // device request as broadcast
    send_frame(random_body(2), 1'b0);                 // short frame
    send_item(CMD_FRAME_END, 8'h00, 7'h00);           // empty frame end
    for (int c = 10; c < 16; c++) send_item(4'(c), 8'hFF, 7'h7F);
  endtask

  // key requests, backlog, goto thresholds and stop at end position
  task automatic test_key_requests();
    logic [3:0] reqs[4];
    logic [6:0] gpos[7];
    reqs = '{CMD_CLOSE, CMD_HALF, CMD_VENT, CMD_STOP};
    gpos = '{7'd0, 7'd5, 7'd6, 7'd50, 7'd94, 7'd95, 7'd127};
    send_item(CMD_OPEN, 8'h00, 7'h00);
    send_item(CMD_LAMP, 8'h00, 7'h00);                // goes to backlog
    send_frame(device_body(0), 1'b0);
    ticks(2);
    send_frame(device_body(0), 1'b0);
    send_frame(device_body(0), 1'b0);                 // backlog taken over
    ticks(2);
    send_frame(device_body(0), 1'b0);
    foreach (reqs[i]) begin
      send_item(reqs[i], 8'h00, 7'h00);
      send_frame(device_body(0), 1'b0);
      ticks(2);
      send_frame(device_body(0), 1'b0);
    end
    foreach (gpos[i]) begin
      send_item(CMD_GOTO, 8'h00, gpos[i]);
      send_frame(device_body(0), 1'b0);
      ticks(2);
      send_frame(device_body(0), 1'b0);
      send_frame(status_body(8'(2 * $urandom_range(100)), 8'd0, 8'd1, 8'h00), 1'b0);
      send_frame(device_body(0), 1'b0);
      ticks(2);
      send_frame(device_body(0), 1'b0);
    end
  endtask

  // a run of bytes that fills the store: the next nonempty frame is dropped
  task automatic test_overflow();
    repeat (RX_DEPTH_DEF) send_item(CMD_RX_BYTE, 8'($urandom), 7'h00);
    send_item(CMD_FRAME_END, 8'h00, 7'h00);           // empty, keeps the drop flag
    send_frame(device_body(0), 1'b0);                 // dropped
    send_frame(device_body(0), 1'b0);
  endtask

  // action timeout with short limits
  task automatic test_timeout();
    send_item(CMD_CLOSE, 8'h00, 7'h00);
    send_frame(device_body(0), 1'b0);
    ticks(int'(m_act_timeout) + 2);
    send_frame(device_body(0), 1'b0);
    send_frame(device_body(0), 1'b0);
  endtask

  // random traffic, mostly well-formed frames with random content
  task automatic test_random(input int n_items);
    int stop_at;
    int pick;
    byte_q_t q;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        send_frame(device_body($urandom_range(9) < 7 ? 0 : $urandom_range(2)),
                   $urandom_range(19) == 0);
      end else if (pick < 55) begin
        send_frame(status_body(8'(2 * $urandom_range(100)), 8'(2 * $urandom_range(100)),
                   $urandom_range(3) == 0 ? 8'h00 : 8'($urandom),
                   $urandom_range(1) ? 8'h10 : 8'h14), $urandom_range(19) == 0);
      end else if (pick < 75) begin
        send_item(4'($urandom_range(CMD_OPEN, CMD_GOTO)), 8'($urandom),
                  $urandom_range(3) == 0 ? 7'($urandom) : 7'($urandom_range(100)));
      end else if (pick < 90) begin
        ticks($urandom_range(1, 12));
      end else begin
        q = random_body($urandom_range(0, 30));
        if (q.size() > 0 && $urandom_range(1)) q[0] = m_dev_addr;
        send_frame(q, 1'($urandom_range(1)));
        if ($urandom_range(3) == 0) send_item(4'($urandom_range(10, 15)), 8'h00, 7'h00);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.command = '0; in_ch.data_byte = '0; in_ch.position = '0;
    out_ch.ready = 1'b0;
    errors = 0; items_sent = 0; results_seen = 0; frames_answered = 0; status_reports = 0;
    sender_idle_pct = 0; recv_stall_pct = 0;
    m_dev_addr = 8'd2; m_key_delay = 16'd100; m_act_timeout = 16'd2000;
    m_vent_target = 8'd8; m_vent_code = 8'd10;
    rx_len = 8'd0; drop_next = 1'b0; key_now = KS_WAIT; key_backlog = KS_WAIT;
    ms_clock = '0; key_stamp = '0; goal_pos = '0;
    s_lamp = 1'b0; s_pos = '0; s_target = '0; s_state = '0; s_res = '0; s_valid = 1'b0;
    foreach (answer[i]) answer[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part with reset configuration, then short delays
    test_status_frames();
    test_device_frames();
    set_config(8'd2, 16'd0, 16'd5, 8'd8, 8'd10);
    test_key_requests();
    test_timeout();
    test_overflow();

    // random phases with different idling and register settings
    set_config(8'd2, 16'd1, 16'd40, 8'd8, 8'd10);
    test_random(RANDOM_ITEMS / 4);
    set_config(8'd255, 16'd0, 16'd0, 8'd0, 8'd255);
    sender_idle_pct = 78;
    test_random(RANDOM_ITEMS / 4);
    set_config(8'd0, 16'd3, 16'd65535, 8'd255, 8'd0);
    sender_idle_pct = 0; recv_stall_pct = 78;
    test_random(RANDOM_ITEMS / 4);
    set_config(8'($urandom_range(1, 254)), 16'd65535, 16'd20, 8'd100, 8'($urandom));
    sender_idle_pct = 31; recv_stall_pct = 31;
    test_random(RANDOM_ITEMS / 4);

    sender_idle_pct = 0; recv_stall_pct = 0;
    drain();

    $display("covered %0d input items, %0d result items: %0d answered device frames, %0d reports",
             items_sent, results_seen, frames_answered, status_reports);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
